[rtl/psm_pkg.sv]
package psm_pkg;

    localparam int IDX_W = 8;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [49:0] term_count;
        logic [5:0]  exponent;
    } t_cmd;

    typedef struct packed {
        logic [31:0] power_sum;
        logic        exponent_too_large;
    } t_res;

    // one matrix element travelling along the cell row
    typedef struct packed {
        logic        valid;
        logic        first;
        logic        last;
        t_idx        row;
        t_idx        step;
        logic [31:0] a;
    } t_tok;

    // shared controls seen by every cell
    typedef struct packed {
        logic        square;
        logic        bank;
        t_idx        last;
        logic        ld_we;
        t_idx        ld_row;
        t_idx        ld_col;
        logic [31:0] ld_data;
    } t_cctl;

    typedef struct packed {
        logic        valid;
        t_idx        row;
        logic [31:0] data;
    } t_cres;

    localparam logic [1:0] RG_ACC = 2'd0;
    localparam logic [1:0] RG_B0  = 2'd1;
    localparam logic [1:0] RG_B1  = 2'd2;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_IDENT = 8'b0000_0100,
        S_STEP  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_SUM   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

[rtl/psm_cell.sv]
module psm_cell #(
    parameter int COL = 0,
    parameter int IW  = 6
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psm_pkg::t_tok  i_tok,
    input  psm_pkg::t_cctl i_ctl,
    output psm_pkg::t_tok  o_tok,
    output psm_pkg::t_cres o_res
);
    import psm_pkg::*;

    localparam int DEPTH = 2 * (1 << IW);

    // column COL of the base matrix, two banks
    logic [31:0] r_mem [DEPTH];
    t_tok        r_tok;
    t_tok        r_tok2;
    logic [31:0] r_b;
    logic [31:0] r_prod;
    logic [31:0] r_acc;
    t_idx        r_row;
    logic        r_done;
    logic        w_active;
    logic        w_ld_hit;

    assign w_active = (IW'(COL) <= i_ctl.last[IW-1:0]);
    assign w_ld_hit = i_ctl.ld_we && (i_ctl.ld_col[IW-1:0] == IW'(COL));

    always_ff @(posedge i_clk) begin
        if (w_ld_hit) begin
            r_mem[{i_ctl.bank, i_ctl.ld_row[IW-1:0]}] <= i_ctl.ld_data;
        end else if (r_done && i_ctl.square) begin
            r_mem[{~i_ctl.bank, r_row[IW-1:0]}] <= r_acc;
        end
        r_b <= r_mem[{i_ctl.bank, i_tok.step[IW-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid  <= 1'b0;
            r_tok2.valid <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_tok  <= i_tok;
            r_tok2 <= r_tok;
            r_done <= r_tok2.valid && r_tok2.last && w_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_tok.a * r_b;
        if (r_tok2.valid) begin
            r_acc <= r_tok2.first ? r_prod : r_acc + r_prod;
            r_row <= r_tok2.row;
        end
    end

    assign o_tok       = r_tok;
    assign o_res.valid = r_done;
    assign o_res.row   = r_row;
    assign o_res.data  = r_acc;

endmodule

[rtl/power_sum_by_matrix_power.sv]
// channel  | handshake            | payload
// command  | start in, busy out   | i_cmd (term_count, exponent)
// result   | o_strobe out         | o_res (power_sum, exponent_too_large)
//
// Trivial cases (exponent too large, one or zero terms, zero exponent) answer
// the cycle after start; busy stays low. Otherwise an identity fill and a base
// load (matrices are sz x sz, sz = exponent+2) precede up to 2*min(COUNT_BITS,50)-1
// matrix products, each feeding one element per cycle into the cell row; then
// row 0 of the result is summed.
// Reset is synchronous, active low, clears control state only; the receiver cannot stall.
module power_sum_by_matrix_power #(
    parameter int MAX_EXPONENT = 62,
    parameter int COUNT_BITS   = 50
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  psm_pkg::t_cmd i_cmd,
    output logic          busy,
    output logic          o_strobe,
    output psm_pkg::t_res o_res
);
    import psm_pkg::*;

    localparam int DIM       = MAX_EXPONENT + 2;
    localparam int IW        = $clog2(DIM);
    localparam int PL        = 1 << IW;
    localparam int NB        = (COUNT_BITS < 50) ? COUNT_BITS : 50;
    localparam int AW        = 2 + 2 * IW;
    localparam int DEPTH     = 1 << AW;
    localparam int DRAIN_CYC = DIM + 6;
    localparam int DCW       = $clog2(DRAIN_CYC + 1);

    t_state          r_state;
    logic [IW-1:0]   r_last;
    logic [NB-1:0]   r_pw;
    logic            r_did;
    logic            r_p;
    logic            r_sq;
    logic [IW-1:0]   r_i;
    logic [IW-1:0]   r_c;
    logic [1:0]      r_src;
    logic [1:0]      r_dst;
    logic [DCW-1:0]  r_dcnt;
    logic [31:0]     r_plm [PL];
    logic [31:0]     r_pld;
    logic [31:0]     r_hold;
    logic            r_lv;
    logic [IW-1:0]   r_lrow;
    logic [IW-1:0]   r_lcol;
    logic [31:0]     r_sum;
    logic            r_sumv;
    t_tok            r_tokm;
    logic [31:0]     r_mem [DEPTH];
    logic [31:0]     r_rd;
    logic            r_we;
    logic [AW-1:0]   r_waddr;
    logic [31:0]     r_wdata;
    logic            r_ld_we;
    logic [IW-1:0]   r_ld_row;
    logic [IW-1:0]   r_ld_col;
    logic [31:0]     r_ld_data;
    logic            r_wb_v;
    logic [AW-1:0]   r_wb_addr;
    logic [31:0]     r_wb_data;
    logic            r_strobe;
    t_res            r_res;

    logic [NB-1:0]   w_n;
    logic            w_too;
    logic [31:0]     w_new;
    logic [AW-1:0]   w_raddr;
    logic [1:0]      w_base;
    logic [1:0]      w_base_nx;
    t_tok            w_tok [DIM];
    t_tok            w_tok_end;
    t_cres           w_cres [DIM];
    t_cctl           w_ctl;
    logic [DIM-1:0]  w_vld;
    logic            w_wb_v;
    logic [IW-1:0]   w_wb_row;
    logic [IW-1:0]   w_wb_col;
    logic [31:0]     w_wb_data;

    assign w_n       = i_cmd.term_count[NB-1:0];
    assign w_too     = ({2'b00, i_cmd.exponent} > 8'(MAX_EXPONENT));
    assign w_base    = r_p ? RG_B1 : RG_B0;
    assign w_base_nx = r_p ? RG_B0 : RG_B1;

    // row r-1 is row r plus row r shifted one column left; row 0 copies row 1
    // behind a leading one, the bottom row is a single one in the last column
    always_comb begin
        if (r_lrow == r_last) begin
            w_new = (r_lcol == r_last) ? 32'd1 : 32'd0;
        end else if (r_lrow == '0) begin
            w_new = (r_lcol == '0) ? 32'd1 : r_pld;
        end else if (r_lcol == r_last) begin
            w_new = r_pld;
        end else begin
            w_new = r_pld + r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_lv) begin
            r_plm[r_lcol] <= w_new;
            r_hold        <= r_pld;
        end
        r_pld <= r_plm[r_c];
    end

    assign w_raddr = (r_state == S_MUL) ? {r_src, r_i, r_c} : {RG_ACC, IW'(0), r_c};

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_mem[r_waddr] <= r_wdata;
        end else if (r_wb_v) begin
            r_mem[r_wb_addr] <= r_wb_data;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_comb begin
        w_ctl.square  = r_sq;
        w_ctl.bank    = r_p;
        w_ctl.last    = t_idx'(r_last);
        w_ctl.ld_we   = r_ld_we;
        w_ctl.ld_row  = t_idx'(r_ld_row);
        w_ctl.ld_col  = t_idx'(r_ld_col);
        w_ctl.ld_data = r_ld_data;
    end

    always_comb begin
        w_tok[0]   = r_tokm;
        w_tok[0].a = r_rd;
    end

    for (genvar j = 0; j < DIM; j++) begin : g_cell
        if (j < DIM - 1) begin : g_mid
            psm_cell #(.COL(j), .IW(IW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[j]),
                .i_ctl   (w_ctl),
                .o_tok   (w_tok[j+1]),
                .o_res   (w_cres[j])
            );
        end else begin : g_end
            psm_cell #(.COL(j), .IW(IW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (w_tok[j]),
                .i_ctl   (w_ctl),
                .o_tok   (w_tok_end),
                .o_res   (w_cres[j])
            );
        end
        assign w_vld[j] = w_cres[j].valid;
    end

    // cells finish a row on distinct cycles, so at most one result a cycle
    always_comb begin
        w_wb_v    = 1'b0;
        w_wb_row  = '0;
        w_wb_col  = '0;
        w_wb_data = '0;
        for (int j = 0; j < DIM; j++) begin
            w_wb_v    = w_wb_v | w_cres[j].valid;
            w_wb_row  = w_wb_row | ({IW{w_cres[j].valid}} & w_cres[j].row[IW-1:0]);
            w_wb_col  = w_wb_col | ({IW{w_cres[j].valid}} & IW'(j));
            w_wb_data = w_wb_data | ({32{w_cres[j].valid}} & w_cres[j].data);
        end
    end

    always_ff @(posedge i_clk) begin
        r_wb_addr <= {r_dst, w_wb_row, w_wb_col};
        r_wb_data <= w_wb_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_strobe     <= 1'b0;
            r_we         <= 1'b0;
            r_ld_we      <= 1'b0;
            r_wb_v       <= 1'b0;
            r_tokm.valid <= 1'b0;
            r_sumv       <= 1'b0;
            r_sq         <= 1'b0;
            r_p          <= 1'b0;
            r_did        <= 1'b0;
            r_lv         <= 1'b0;
        end else begin
            r_strobe     <= 1'b0;
            r_we         <= 1'b0;
            r_ld_we      <= 1'b0;
            r_wb_v       <= w_wb_v;
            r_tokm.valid <= 1'b0;
            r_lv         <= 1'b0;
            r_sumv       <= (r_state == S_SUM);
            if (r_sumv) begin
                r_sum <= r_sum + r_rd;
            end
            // write the base element, built from the previous row read back in the previous cycle
            if (r_lv) begin
                r_we      <= 1'b1;
                r_waddr   <= {RG_B0, r_lrow, r_lcol};
                r_wdata   <= w_new;
                r_ld_we   <= 1'b1;
                r_ld_row  <= r_lrow;
                r_ld_col  <= r_lcol;
                r_ld_data <= w_new;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_res.exponent_too_large <= w_too;
                        r_res.power_sum          <= '0;
                        if (w_too || w_n == '0) begin
                            r_strobe <= 1'b1;
                        end else if (w_n == NB'(1)) begin
                            r_strobe        <= 1'b1;
                            r_res.power_sum <= 32'd1;
                        end else if (i_cmd.exponent == '0) begin
                            r_strobe        <= 1'b1;
                            r_res.power_sum <= 32'(w_n);
                        end else begin
                            r_last  <= IW'(7'(i_cmd.exponent) + 7'd1);
                            r_pw    <= w_n - NB'(1);
                            r_i     <= '0;
                            r_c     <= '0;
                            r_p     <= 1'b0;
                            r_sq    <= 1'b0;
                            r_state <= S_IDENT;
                        end
                    end
                end
                S_IDENT: begin
                    r_we    <= 1'b1;
                    r_waddr <= {RG_ACC, r_i, r_c};
                    r_wdata <= (r_i == r_c) ? 32'd1 : 32'd0;
                    r_c     <= r_c + IW'(1);
                    if (r_c == r_last) begin
                        r_c <= '0;
                        r_i <= r_i + IW'(1);
                        if (r_i == r_last) begin
                            r_i     <= r_last;
                            r_c     <= r_last;
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_LOAD: begin
                    // walk rows bottom-up and columns right to left
                    r_lv   <= 1'b1;
                    r_lrow <= r_i;
                    r_lcol <= r_c;
                    r_c    <= r_c - IW'(1);
                    if (r_c == '0) begin
                        r_c <= r_last;
                        r_i <= r_i - IW'(1);
                        if (r_i == '0) begin
                            r_did   <= 1'b0;
                            r_dcnt  <= '0;
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_STEP: begin
                    r_i <= '0;
                    r_c <= '0;
                    if (r_pw == '0) begin
                        r_sum   <= '0;
                        r_state <= S_SUM;
                    end else if (r_pw[0] && !r_did) begin
                        r_did   <= 1'b1;
                        r_src   <= RG_ACC;
                        r_dst   <= RG_ACC;
                        r_sq    <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        r_pw  <= r_pw >> 1;
                        r_did <= 1'b0;
                        if ((r_pw >> 1) != '0) begin
                            r_src   <= w_base;
                            r_dst   <= w_base_nx;
                            r_sq    <= 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_tokm.valid <= 1'b1;
                    r_tokm.first <= (r_c == '0);
                    r_tokm.last  <= (r_c == r_last);
                    r_tokm.row   <= t_idx'(r_i);
                    r_tokm.step  <= t_idx'(r_c);
                    r_tokm.a     <= '0;
                    r_c          <= r_c + IW'(1);
                    if (r_c == r_last) begin
                        r_c <= '0;
                        r_i <= r_i + IW'(1);
                        if (r_i == r_last) begin
                            r_dcnt  <= '0;
                            r_state <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN: begin
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(DRAIN_CYC - 1)) begin
                        if (r_sq) begin
                            r_p <= ~r_p;
                        end
                        r_sq    <= 1'b0;
                        r_state <= S_STEP;
                    end
                end
                S_SUM: begin
                    r_c <= r_c + IW'(1);
                    if (r_c == r_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_strobe                 <= 1'b1;
                    r_res.power_sum          <= r_sum + r_rd;
                    r_res.exponent_too_large <= 1'b0;
                    r_state                  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld))
        else $error("two cells finished in the same cycle");

    a_tok_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_end.valid |-> (r_state == S_MUL || r_state == S_DRAIN))
        else $error("token in cell row outside a product");

    a_mul_pw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_pw != '0))
        else $error("product started with exhausted power");

    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_v |-> !r_we)
        else $error("load and write-back collide on memory port");

endmodule
